[rtl/fcgi_pkg.sv]
`default_nettype none
package fcgi_pkg;
  localparam int unsigned HeaderBytesDefault = 8;
  localparam logic [7:0] TypeParams = 8'd4;
  localparam logic [7:0] TypeStdin  = 8'd5;
  localparam int unsigned QueueDepth = 2;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_CONTENT = 2'd1,
    PH_PADDING = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    PP_NAME_LEN  = 2'd0,
    PP_VALUE_LEN = 2'd1,
    PP_NAME      = 2'd2,
    PP_VALUE     = 2'd3
  } pparam_e;

  typedef enum logic [1:0] {
    CLS_NONE  = 2'd0,
    CLS_NAME  = 2'd1,
    CLS_VALUE = 2'd2,
    CLS_STDIN = 2'd3
  } cls_e;

  localparam logic [0:0] RegAcceptedVersion = 1'b0;

  // one classified beat handed from the framer to the pair splitter
  typedef struct packed {
    logic [7:0]  data;
    logic [15:0] id;
    logic        params;
    logic        stdin;
    logic        new_rec;
    logic        done;
    logic        trunc;
    logic        last;
  } beat_t;
endpackage
`default_nettype wire

[rtl/fastcgi_record_deframer.sv]
`default_nettype none
// fastcgi record deframer
// input channel: push / full with data_byte_i and last_i, one beat per
//   received byte; a beat is taken at a clock edge with push high, full low
// result channel: empty / pop; the oldest result sits on the ports while
//   empty is low and leaves on an edge with pop high
// each input beat gives exactly one result beat with its class, the byte,
//   the request id and the pair / record / truncation flags
// the framer and pair splitter work combinationally on the accepted beat and
//   write a two-entry result queue, so each result is registered before it
//   reaches the ports; one beat per clock is sustained while full is low
// when the receiver stalls the queue fills and full rises after two
//   waiting results; full drops as soon as a result is popped
// reset puts the parser at the start of a header, empties the queue and
//   sets accepted_version to 1; accepted_version is written through the apb
//   port at address 0; the user must write it only while idle (not enforced)
module fastcgi_record_deframer
  import fcgi_pkg::*;
#(
  parameter int unsigned HeaderBytes = HeaderBytesDefault,
  parameter int unsigned Depth       = QueueDepth
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [0:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        last_i,
  output logic             empty,
  input  wire logic        pop,
  output logic [1:0]       byte_class_o,
  output logic [7:0]       out_byte_o,
  output logic [15:0]      rec_id_o,
  output logic             pair_done_o,
  output logic             record_done_o,
  output logic             truncated_o
);
  localparam int unsigned ResW = 2 + 8 + 16 + 3;

  logic [7:0]      acc_ver_q;
  logic            in_fire;
  beat_t           beat;
  logic [1:0]      cls;
  logic            pair;
  logic [ResW-1:0] res_in, res_out;

  // configuration register, always ready
  assign pready = 1'b1;
  assign prdata = (paddr == RegAcceptedVersion) ? {24'd0, acc_ver_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_ver_q <= 8'd1;
    end else if (psel && penable && pwrite && paddr == RegAcceptedVersion) begin
      acc_ver_q <= pwdata[7:0];
    end
  end

  assign in_fire = push && !full;

  // front: header assembly and record bookkeeping
  fcgi_framer #(.HeaderBytes(HeaderBytes)) u_framer (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .acc_ver_i  (acc_ver_q),
    .in_valid_i (in_fire),
    .data_byte_i(data_byte_i),
    .last_i     (last_i),
    .beat_o     (beat)
  );

  // name / value splitting of params content
  fcgi_splitter u_split (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(in_fire),
    .beat_i (beat),
    .cls_o  (cls),
    .pair_o (pair)
  );

  assign res_in = {cls, beat.data, beat.id, pair, beat.done, beat.trunc};

  // result queue decouples the receiver
  fcgi_queue #(.Width(ResW), .Depth(Depth)) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (in_fire),
    .data_i (res_in),
    .full_o (full),
    .pop_i  (pop),
    .data_o (res_out),
    .empty_o(empty)
  );

  assign {byte_class_o, out_byte_o, rec_id_o, pair_done_o, record_done_o,
          truncated_o} = res_out;

  // a pair can only complete on params content
  a_pair_params: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && pair |-> beat.params)
    else $error("pair done outside params content");

  // name / value class only on params content
  a_cls_params: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && (cls == CLS_NAME || cls == CLS_VALUE) |-> beat.params)
    else $error("param class outside params content");

  // truncation only flagged on the final byte
  a_trunc_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && beat.trunc |-> last_i)
    else $error("truncation without last");

  // a push into a non-full queue leaves it non-empty
  a_push_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !empty)
    else $error("result lost after push");
endmodule
`default_nettype wire

[rtl/fcgi_framer.sv]
`default_nettype none
module fcgi_framer
  import fcgi_pkg::*;
#(
  parameter int unsigned HeaderBytes = HeaderBytesDefault
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic [7:0] acc_ver_i,
  input  wire logic       in_valid_i,
  input  wire logic [7:0] data_byte_i,
  input  wire logic       last_i,
  output beat_t           beat_o
);
  localparam int unsigned CntW = $clog2(HeaderBytes);

  phase_e            phase_q, phase_d;
  logic [CntW-1:0]   hcnt_q, hcnt_d;
  logic [7:0]        ver_q, ver_d, type_q, type_d, pad_q, pad_d;
  logic [15:0]       id_q, id_d, clen_q, clen_d;
  logic [15:0]       clen_dec;
  logic [7:0]        pad_dec;
  logic              done, trunc, match, new_rec;

  assign clen_dec = clen_q - 16'd1;
  assign pad_dec  = pad_q - 8'd1;
  assign match    = (ver_q == acc_ver_i);

  always_comb begin
    phase_d = phase_q;
    hcnt_d  = hcnt_q;
    ver_d   = ver_q;
    type_d  = type_q;
    id_d    = id_q;
    clen_d  = clen_q;
    pad_d   = pad_q;
    done    = 1'b0;
    new_rec = 1'b0;
    case (phase_q)
      PH_CONTENT: begin
        clen_d = clen_dec;
        if (clen_dec == 16'd0) begin
          if (pad_q != 8'd0) phase_d = PH_PADDING;
          else begin
            phase_d = PH_HEADER;
            done    = 1'b1;
          end
        end
      end
      PH_PADDING: begin
        pad_d = pad_dec;
        if (pad_dec == 8'd0) begin
          phase_d = PH_HEADER;
          done    = 1'b1;
        end
      end
      default: begin
        phase_d = PH_HEADER;
        case (hcnt_q)
          CntW'(0): begin
            ver_d   = data_byte_i;
            id_d    = 16'd0;
            new_rec = 1'b1;
          end
          CntW'(1): type_d = data_byte_i;
          CntW'(2): id_d = {data_byte_i, 8'd0};
          CntW'(3): id_d = {id_q[15:8], data_byte_i};
          CntW'(4): clen_d = {data_byte_i, 8'd0};
          CntW'(5): clen_d = {clen_q[15:8], data_byte_i};
          CntW'(6): pad_d = data_byte_i;
          default: ;
        endcase
        if (hcnt_q == CntW'(HeaderBytes - 1)) begin
          hcnt_d = '0;
          if (clen_d != 16'd0) phase_d = PH_CONTENT;
          else if (pad_d != 8'd0) phase_d = PH_PADDING;
          else done = 1'b1;
        end else begin
          hcnt_d = hcnt_q + CntW'(1);
        end
      end
    endcase
    trunc = 1'b0;
    if (last_i) begin
      trunc   = !(phase_d == PH_HEADER && hcnt_d == '0);
      phase_d = PH_HEADER;
      hcnt_d  = '0;
      clen_d  = 16'd0;
      pad_d   = 8'd0;
    end
  end

  always_comb begin
    beat_o.data    = data_byte_i;
    beat_o.id      = id_d;
    beat_o.params  = (phase_q == PH_CONTENT) && match && (type_q == TypeParams);
    beat_o.stdin   = (phase_q == PH_CONTENT) && match && (type_q == TypeStdin);
    beat_o.new_rec = new_rec;
    beat_o.done    = done;
    beat_o.trunc   = trunc;
    beat_o.last    = last_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEADER;
      hcnt_q  <= '0;
      ver_q   <= 8'd0;
      type_q  <= 8'd0;
      id_q    <= 16'd0;
      clen_q  <= 16'd0;
      pad_q   <= 8'd0;
    end else if (in_valid_i) begin
      phase_q <= phase_d;
      hcnt_q  <= hcnt_d;
      ver_q   <= ver_d;
      type_q  <= type_d;
      id_q    <= id_d;
      clen_q  <= clen_d;
      pad_q   <= pad_d;
    end
  end
endmodule
`default_nettype wire

[rtl/fcgi_splitter.sv]
`default_nettype none
module fcgi_splitter
  import fcgi_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        valid_i,
  input  beat_t            beat_i,
  output logic [1:0]       cls_o,
  output logic             pair_o
);
  pparam_e    pp_q, pp_d;
  logic [7:0] name_q, name_d, val_q, val_d, name_dec, val_dec;
  pparam_e    pp_cur;
  logic [7:0] name_cur, val_cur;

  assign pp_cur   = beat_i.new_rec ? PP_NAME_LEN : pp_q;
  assign name_cur = beat_i.new_rec ? 8'd0 : name_q;
  assign val_cur  = beat_i.new_rec ? 8'd0 : val_q;
  assign name_dec = name_cur - 8'd1;
  assign val_dec  = val_cur - 8'd1;

  always_comb begin
    pp_d   = pp_cur;
    name_d = name_cur;
    val_d  = val_cur;
    cls_o  = CLS_NONE;
    pair_o = 1'b0;
    if (beat_i.stdin) cls_o = CLS_STDIN;
    if (beat_i.params) begin
      case (pp_cur)
        PP_NAME_LEN: begin
          name_d = beat_i.data;
          pp_d   = PP_VALUE_LEN;
        end
        PP_VALUE_LEN: begin
          val_d = beat_i.data;
          if (name_cur != 8'd0) pp_d = PP_NAME;
          else if (beat_i.data != 8'd0) pp_d = PP_VALUE;
          else begin
            pair_o = 1'b1;
            pp_d   = PP_NAME_LEN;
          end
        end
        PP_NAME: begin
          cls_o  = CLS_NAME;
          name_d = name_dec;
          if (name_dec == 8'd0) begin
            if (val_cur != 8'd0) pp_d = PP_VALUE;
            else begin
              pair_o = 1'b1;
              pp_d   = PP_NAME_LEN;
            end
          end
        end
        default: begin
          cls_o = CLS_VALUE;
          val_d = val_dec;
          if (val_dec == 8'd0) begin
            pair_o = 1'b1;
            pp_d   = PP_NAME_LEN;
          end
        end
      endcase
    end
    if (beat_i.last) begin
      pp_d   = PP_NAME_LEN;
      name_d = 8'd0;
      val_d  = 8'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pp_q   <= PP_NAME_LEN;
      name_q <= 8'd0;
      val_q  <= 8'd0;
    end else if (valid_i) begin
      pp_q   <= pp_d;
      name_q <= name_d;
      val_q  <= val_d;
    end
  end
endmodule
`default_nettype wire

[rtl/fcgi_queue.sv]
`default_nettype none
module fcgi_queue
  import fcgi_pkg::*;
#(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = QueueDepth
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [Width-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic [Width-1:0]      data_o,
  output logic                  empty_o
);
  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_q, rd_q;
  logic [PtrW:0]    cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == (PtrW+1)'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
      if (do_pop)  rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
      cnt_q <= cnt_q + (PtrW+1)'(do_push) - (PtrW+1)'(do_pop);
    end
  end
endmodule
`default_nettype wire
